// ----- hw/rtl/dbms_pkg.sv -----
// Shared constants, types and helpers for the debounced button menu selector.
`timescale 1ns / 1ps

package dbms_pkg;

  localparam int MAX_TASKS   = 8;
  localparam int SEL_W       = 3;
  localparam int TIME_W      = 32;
  localparam int DEBOUNCE_W  = 16;
  localparam int COUNT_W     = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // The selection is three bits wide, so at most eight entries can be used.
  localparam int COUNT_LIMIT = (MAX_TASKS < 8) ? MAX_TASKS : 8;

  localparam logic [CFG_IDX_W-1:0]  REG_DEBOUNCE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_TASK_COUNT   = 1'b1;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 16'd30;
  localparam logic [COUNT_W-1:0]    TASK_COUNT_RESET = 4'd4;

  typedef struct packed {
    logic up;
    logic down;
    logic run;
  } dbms_events_t;

  // Number of usable menu entries: zero counts as one, and large values are clamped.
  function automatic logic [COUNT_W-1:0] entry_count(input logic [COUNT_W-1:0] task_count);
    logic [COUNT_W-1:0] n;
    n = task_count;
    if (n == '0) begin
      n = COUNT_W'(1);
    end
    if (n > COUNT_W'(COUNT_LIMIT)) begin
      n = COUNT_W'(COUNT_LIMIT);
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/dbms_poll_if.sv -----
// Poll channel: timestamp and raw levels of the three buttons.
`timescale 1ns / 1ps

interface dbms_poll_if;
  logic                     valid;
  logic                     ready;
  logic [dbms_pkg::TIME_W-1:0] now_ms;
  logic                     up_level;
  logic                     down_level;
  logic                     run_level;

  modport source (output valid, output now_ms, output up_level, output down_level,
                  output run_level, input ready);
  modport sink (input valid, input now_ms, input up_level, input down_level,
                input run_level, output ready);
endinterface

// ----- hw/rtl/dbms_result_if.sv -----
// Result channel: run event and selection after each poll.
`timescale 1ns / 1ps

interface dbms_result_if;
  logic                       valid;
  logic                       ready;
  logic                       run_fired;
  logic [dbms_pkg::SEL_W-1:0] chosen_task;
  logic [dbms_pkg::SEL_W-1:0] current_selection;

  modport source (output valid, output run_fired, output chosen_task,
                  output current_selection, input ready);
  modport sink (input valid, input run_fired, input chosen_task,
                input current_selection, output ready);
endinterface

// ----- hw/rtl/debounced_button_menu_selector.sv -----
// Top level of the debounced three-button menu selector.
//
//   Channel  Dir  Handshake      Beat contents
//   poll     in   valid/ready    now_ms, up_level, down_level, run_level
//   result   out  valid/ready    run_fired, chosen_task, current_selection
//   cfg      in   cfg_we         cfg_index, cfg_data (debounce_ms, task_count)
//
// One poll per clock while the result side is not stalled. The poll is held in
// an input register, then the debouncers and the selection logic settle and the
// result lands in the output register.
// A stalled result holds both stages; the poll side stays ready while the
// input register is empty. Synchronous reset releases all buttons, zeroes the
// selection and restores the register defaults.
`timescale 1ns / 1ps

module debounced_button_menu_selector (
  input  logic                             clk,
  input  logic                             rst,
  dbms_poll_if.sink                        poll,
  dbms_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [dbms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dbms_pkg::*;

  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic [COUNT_W-1:0]    task_count;

  logic              s1_valid;
  logic [TIME_W-1:0] s1_now;
  logic              s1_up;
  logic              s1_down;
  logic              s1_run;

  logic              advance;
  dbms_events_t      events;
  logic [SEL_W-1:0]  selection_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      task_count  <= TASK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ms <= cfg_data[DEBOUNCE_W-1:0];
        REG_TASK_COUNT: task_count  <= cfg_data[COUNT_W-1:0];
        default:        ;
      endcase
    end
  end

  assign advance    = s1_valid && (!result.valid || result.ready);
  assign poll.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_now  <= poll.now_ms;
      s1_up   <= poll.up_level;
      s1_down <= poll.down_level;
      s1_run  <= poll.run_level;
    end
  end

  dbms_button u_up (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .level       (s1_up),
    .now_ms      (s1_now),
    .debounce_ms (debounce_ms),
    .press       (events.up)
  );

  dbms_button u_down (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .level       (s1_down),
    .now_ms      (s1_now),
    .debounce_ms (debounce_ms),
    .press       (events.down)
  );

  dbms_button u_run (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .level       (s1_run),
    .now_ms      (s1_now),
    .debounce_ms (debounce_ms),
    .press       (events.run)
  );

  dbms_select u_select (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .events         (events),
    .task_count     (task_count),
    .selection_next (selection_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.run_fired         <= events.run;
      result.chosen_task       <= events.run ? selection_next : '0;
      result.current_selection <= selection_next;
    end
  end

  // A run beat always reports the selection that travels with it.
  a_run_reports_selection: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.run_fired |-> result.chosen_task == result.current_selection)
    else $error("chosen_task differs from current_selection on a run beat");

  a_idle_task_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.run_fired |-> result.chosen_task == '0)
    else $error("chosen_task not zero without a run event");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.valid)
    else $error("result register empty after a poll moved into it");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_now))
    else $error("held poll lost while the result side stalled");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> poll.ready)
    else $error("poll side stalled with an empty input register");

endmodule

// ----- hw/rtl/dbms_button.sv -----
// Timestamp debouncer for one button, producing a press event per poll.
`timescale 1ns / 1ps

module dbms_button (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            level,
  input  logic [dbms_pkg::TIME_W-1:0]     now_ms,
  input  logic [dbms_pkg::DEBOUNCE_W-1:0] debounce_ms,
  output logic                            press
);
  import dbms_pkg::*;

  logic              stable;
  logic              candidate;
  logic [TIME_W-1:0] candidate_time;
  logic [TIME_W-1:0] elapsed;
  logic              settled;

  // Modulo subtraction keeps the elapsed time correct across timestamp wrap.
  assign elapsed = now_ms - candidate_time;
  assign settled = (level == candidate) && (level != stable) &&
                   (elapsed >= TIME_W'(debounce_ms));
  assign press   = settled && level;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable    <= 1'b0;
      candidate <= 1'b0;
    end else if (step) begin
      if (level != candidate) begin
        candidate <= level;
      end else if (settled) begin
        stable <= level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && (level != candidate)) begin
      candidate_time <= now_ms;
    end
  end

endmodule

// ----- hw/rtl/dbms_select.sv -----
// Menu selection register, moved by the up and down press events.
`timescale 1ns / 1ps

module dbms_select (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  dbms_pkg::dbms_events_t       events,
  input  logic [dbms_pkg::COUNT_W-1:0] task_count,
  output logic [dbms_pkg::SEL_W-1:0]   selection_next
);
  import dbms_pkg::*;

  logic [SEL_W-1:0]   selection;
  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] sel_plus;

  assign n        = entry_count(task_count);
  assign sel_plus = COUNT_W'(selection) + COUNT_W'(1);

  // Up takes precedence when both up and down fire in the same poll.
  always_comb begin
    selection_next = selection;
    if (events.up) begin
      if (selection == '0) begin
        selection_next = SEL_W'(n - COUNT_W'(1));
      end else begin
        selection_next = selection - SEL_W'(1);
      end
    end else if (events.down) begin
      if (sel_plus >= n) begin
        selection_next = '0;
      end else begin
        selection_next = SEL_W'(sel_plus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selection <= '0;
    end else if (step) begin
      selection <= selection_next;
    end
  end

endmodule

// ----- verif/tb_debounced_button_menu_selector.sv -----
// Self-checking testbench for the debounced three-button menu selector.
`timescale 1ns / 1ps

module tb_debounced_button_menu_selector;
  import dbms_pkg::*;

  localparam int BTN_UP   = 0;
  localparam int BTN_DOWN = 1;
  localparam int BTN_RUN  = 2;

  typedef struct packed {
    logic             run_fired;
    logic [SEL_W-1:0] chosen_task;
    logic [SEL_W-1:0] current_selection;
  } menu_result_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dbms_poll_if   poll_bus ();
  dbms_result_if result_bus ();

  debounced_button_menu_selector u_dut (
    .clk       (clk),
    .rst       (rst),
    .poll      (poll_bus),
    .result    (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: debounced buttons, selection and register copies.
  logic [2:0]          btn_stable;
  logic [2:0]          btn_candidate;
  logic [TIME_W-1:0]   btn_since [3];
  logic [SEL_W-1:0]    menu_sel;
  logic [DEBOUNCE_W-1:0] debounce_copy;
  logic [COUNT_W-1:0]  task_count_copy;

  menu_result_t pending_results [$];
  int fail_count = 0;
  bit idle_on = 1'b1;

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic reset_model();
    btn_stable      = '0;
    btn_candidate   = '0;
    btn_since       = '{default: '0};
    menu_sel        = '0;
    debounce_copy   = DEBOUNCE_RESET;
    task_count_copy = TASK_COUNT_RESET;
  endtask

  // Returns 1 when this poll settles a button into the pressed level.
  function automatic logic debounce_press(input int b, input logic lvl,
                                          input logic [TIME_W-1:0] now);
    if (lvl != btn_candidate[b]) begin
      btn_candidate[b] = lvl;
      btn_since[b]     = now;
      return 1'b0;
    end
    if (lvl != btn_stable[b] && (now - btn_since[b]) >= {16'd0, debounce_copy}) begin
      btn_stable[b] = lvl;
      return lvl;
    end
    return 1'b0;
  endfunction

  function automatic menu_result_t predict_menu(input logic [TIME_W-1:0] now,
                                                input logic up, input logic down,
                                                input logic run);
    logic up_ev, down_ev, run_ev;
    int entries, sel;
    menu_result_t r;
    entries = (task_count_copy == 0) ? 1 : int'(task_count_copy);
    if (entries > COUNT_LIMIT) entries = COUNT_LIMIT;
    up_ev   = debounce_press(BTN_UP, up, now);
    down_ev = debounce_press(BTN_DOWN, down, now);
    run_ev  = debounce_press(BTN_RUN, run, now);
    sel = int'(menu_sel);
    // Up takes priority; a selection above a lowered count steps down on up and wraps on down.
    if (up_ev) begin
      sel = (sel == 0) ? entries - 1 : sel - 1;
    end else if (down_ev) begin
      sel = (sel + 1 >= entries) ? 0 : sel + 1;
    end
    menu_sel = SEL_W'(sel);
    r.run_fired         = run_ev;
    r.chosen_task       = run_ev ? menu_sel : '0;
    r.current_selection = menu_sel;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Valid stays high across back-to-back beats; this task lowers it only for a gap.
  task automatic send_poll(input logic [TIME_W-1:0] now, input logic up,
                           input logic down, input logic run);
    int gap;
    poll_bus.valid      <= 1'b1;
    poll_bus.now_ms     <= now;
    poll_bus.up_level   <= up;
    poll_bus.down_level <= down;
    poll_bus.run_level  <= run;
    @(posedge clk);
    while (poll_bus.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(predict_menu(now, up, down, run));
    gap = pick_gap();
    if (gap > 0) begin
      poll_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off new polls until every outstanding result has been taken.
  task automatic settle();
    poll_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; the task count word has
  // random upper bits, which the block must ignore.
  task automatic program_regs(input logic [DEBOUNCE_W-1:0] debounce,
                              input logic [COUNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] count_word;
    count_word = {12'($urandom), count};
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= debounce;
    @(posedge clk);
    cfg_index <= REG_TASK_COUNT;
    cfg_data  <= count_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_copy   = debounce;
    task_count_copy = count_word[COUNT_W-1:0];
  endtask

  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_poll(32'd0, 1'b1, 1'b0, 1'b0);
    send_poll(32'd29, 1'b1, 1'b0, 1'b0);   // one millisecond short
    send_poll(32'd30, 1'b1, 1'b0, 1'b0);   // up from zero wraps to the top entry
    send_poll(32'd31, 1'b1, 1'b1, 1'b1);
    send_poll(32'd61, 1'b0, 1'b1, 1'b1);   // down and run settle together
    send_poll(32'd62, 1'b0, 1'b1, 1'b0);
    send_poll(32'd92, 1'b0, 1'b0, 1'b0);
    send_poll(32'd122, 1'b0, 1'b0, 1'b0);
    send_poll(32'd123, 1'b1, 1'b1, 1'b1);
    send_poll(32'd153, 1'b1, 1'b1, 1'b1);  // up beats down, run reports the move
    send_poll(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_000E, 1'b0, 1'b0, 1'b0);  // elapsed time across the wrap
    send_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    send_poll(32'h0000_001D, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_register_corners();
    settle();
    program_regs(16'd0, 4'd8);
    send_poll(32'h20, 1'b0, 1'b0, 1'b0);
    send_poll(32'h20, 1'b1, 1'b0, 1'b0);
    send_poll(32'h20, 1'b1, 1'b0, 1'b0);   // zero debounce accepts on the next poll
    settle();
    program_regs(16'd0, 4'd0);             // zero count behaves as one entry
    send_poll(32'h21, 1'b0, 1'b0, 1'b0);
    send_poll(32'h21, 1'b0, 1'b0, 1'b0);
    send_poll(32'h21, 1'b1, 1'b0, 1'b0);
    send_poll(32'h21, 1'b1, 1'b0, 1'b0);   // selection above the count steps down
    send_poll(32'h22, 1'b1, 1'b1, 1'b0);
    send_poll(32'h22, 1'b1, 1'b1, 1'b0);
    settle();
    program_regs(16'd0, 4'd15);            // clamped to eight entries
    send_poll(32'h23, 1'b0, 1'b0, 1'b0);
    send_poll(32'h23, 1'b0, 1'b0, 1'b0);
    send_poll(32'h23, 1'b1, 1'b0, 1'b0);
    send_poll(32'h23, 1'b1, 1'b0, 1'b0);
    settle();
    program_regs(16'hFFFF, 4'd15);
    send_poll(32'h100, 1'b0, 1'b0, 1'b0);
    send_poll(32'h100 + 32'd65534, 1'b0, 1'b0, 1'b0);
    send_poll(32'h100 + 32'd65535, 1'b0, 1'b0, 1'b0);
  endtask

  // Buttons are mostly held at an intended level with occasional bounce, and
  // time moves in steps sized to the debounce window so that presses settle.
  task automatic run_menu_phase(input logic [DEBOUNCE_W-1:0] debounce,
                                input logic [COUNT_W-1:0] count, input int polls,
                                input bit idle, input logic [TIME_W-1:0] start_ms);
    logic [TIME_W-1:0] stamp;
    logic [2:0] held;
    logic [2:0] raw;
    int roll;
    int reach;
    settle();
    program_regs(debounce, count);
    idle_on = idle;
    stamp = start_ms;
    held  = '0;
    reach = int'(debounce) / 3 + 2;
    repeat (polls) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        if (roll < 9) stamp += $urandom_range(0, 3 * int'(debounce) + 3);
        else stamp += $urandom_range(0, reach);
        for (int b = 0; b < 3; b++) begin
          if ($urandom_range(0, 24) == 0) held[b] = ~held[b];
          raw[b] = held[b] ^ ($urandom_range(0, 9) == 0);
        end
        send_poll(stamp, raw[BTN_UP], raw[BTN_DOWN], raw[BTN_RUN]);
      end
    end
  endtask

  task automatic test_random_menu();
    run_menu_phase(16'd30, 4'd4, 300, 1'b1, $urandom);
    run_menu_phase(16'd0, 4'd1, 200, 1'b0, $urandom);
    run_menu_phase(16'hFFFF, 4'd8, 250, 1'b1, 32'hFFFF_0000);
    run_menu_phase(16'd5, 4'd15, 250, 1'b1, $urandom);
    run_menu_phase(16'd1, 4'd0, 150, 1'b1, 32'hFFFF_FFC0);
    run_menu_phase(16'd12, 4'd3, 250, 1'b0, $urandom);
    run_menu_phase(16'd100, 4'd10, 250, 1'b1, $urandom);
    run_menu_phase(16'd20, 4'd8, 150, 1'b1, $urandom);
    // Lowering the count can leave the selection above the new range.
    run_menu_phase(16'd20, 4'd2, 150, 1'b1, $urandom);
  endtask

  initial begin : result_sink
    menu_result_t want;
    int hold;
    hold = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no poll outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_bus.run_fired !== want.run_fired) begin
            $error("run_fired: expected %0d, got %0d", want.run_fired, result_bus.run_fired);
            fail_count++;
          end
          if (result_bus.chosen_task !== want.chosen_task) begin
            $error("chosen_task: expected %0d, got %0d", want.chosen_task,
                   result_bus.chosen_task);
            fail_count++;
          end
          if (result_bus.current_selection !== want.current_selection) begin
            $error("current_selection: expected %0d, got %0d", want.current_selection,
                   result_bus.current_selection);
            fail_count++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
      end else if (!idle_on) begin
        result_bus.ready <= 1'b1;
      end else begin
        hold = pick_gap();
        result_bus.ready <= (hold == 0);
        if (hold == 0) hold = $urandom_range(0, 6);
        else hold = hold - 1;
      end
    end
  end

  initial begin : stimulus
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_DEBOUNCE;
    cfg_data            = '0;
    poll_bus.valid      = 1'b0;
    poll_bus.now_ms     = '0;
    poll_bus.up_level   = 1'b0;
    poll_bus.down_level = 1'b0;
    poll_bus.run_level  = 1'b0;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_corners();
    test_random_menu();
    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
